@@ rtl/tksd_pkg.sv @@
// Package for the terminal key sequence decoder: key kind codes, byte codes,
// parser phase type, the result record and the table for tilde-ended CSI codes.
// Depends on nothing.
`timescale 1ns / 1ps

package tksd_pkg;

  // Key kind codes carried on the result.
  localparam logic [4:0] KIND_NONE   = 5'd0;
  localparam logic [4:0] KIND_CHAR   = 5'd1;
  localparam logic [4:0] KIND_TAB    = 5'd2;
  localparam logic [4:0] KIND_ENTER  = 5'd3;
  localparam logic [4:0] KIND_SPACE  = 5'd4;
  localparam logic [4:0] KIND_BKSP   = 5'd5;
  localparam logic [4:0] KIND_UP     = 5'd6;
  localparam logic [4:0] KIND_DOWN   = 5'd7;
  localparam logic [4:0] KIND_RIGHT  = 5'd8;
  localparam logic [4:0] KIND_LEFT   = 5'd9;
  localparam logic [4:0] KIND_END    = 5'd10;
  localparam logic [4:0] KIND_HOME   = 5'd11;
  localparam logic [4:0] KIND_INS    = 5'd12;
  localparam logic [4:0] KIND_DEL    = 5'd13;
  localparam logic [4:0] KIND_PGUP   = 5'd14;
  localparam logic [4:0] KIND_PGDN   = 5'd15;
  localparam logic [4:0] KIND_F0     = 5'd16;
  localparam logic [4:0] KIND_F1     = 5'd17;
  localparam logic [4:0] KIND_F2     = 5'd18;
  localparam logic [4:0] KIND_F3     = 5'd19;
  localparam logic [4:0] KIND_F4     = 5'd20;
  localparam logic [4:0] KIND_F5     = 5'd21;
  localparam logic [4:0] KIND_F6     = 5'd22;
  localparam logic [4:0] KIND_F7     = 5'd23;
  localparam logic [4:0] KIND_F8     = 5'd24;
  localparam logic [4:0] KIND_F9     = 5'd25;
  localparam logic [4:0] KIND_F10    = 5'd26;
  localparam logic [4:0] KIND_F11    = 5'd27;
  localparam logic [4:0] KIND_F12    = 5'd28;

  // Bit positions in the gathered modifier set.
  localparam int MOD_SHIFT_BIT = 0;
  localparam int MOD_ALT_BIT   = 1;
  localparam int MOD_CTRL_BIT  = 2;

  // Byte codes the parser looks for.
  localparam logic [7:0] BYTE_NUL      = 8'h00;
  localparam logic [7:0] BYTE_TAB      = 8'h09;
  localparam logic [7:0] BYTE_CR       = 8'h0D;
  localparam logic [7:0] BYTE_ESC      = 8'h1B;
  localparam logic [7:0] BYTE_SPACE    = 8'h20;
  localparam logic [7:0] BYTE_DIGIT_0  = 8'h30;
  localparam logic [7:0] BYTE_DIGIT_9  = 8'h39;
  localparam logic [7:0] BYTE_SEMI     = 8'h3B;
  localparam logic [7:0] BYTE_UPPER_A  = 8'h41;
  localparam logic [7:0] BYTE_UPPER_B  = 8'h42;
  localparam logic [7:0] BYTE_UPPER_C  = 8'h43;
  localparam logic [7:0] BYTE_UPPER_D  = 8'h44;
  localparam logic [7:0] BYTE_UPPER_F  = 8'h46;
  localparam logic [7:0] BYTE_UPPER_H  = 8'h48;
  localparam logic [7:0] BYTE_UPPER_O  = 8'h4F;
  localparam logic [7:0] BYTE_UPPER_P  = 8'h50;
  localparam logic [7:0] BYTE_UPPER_Q  = 8'h51;
  localparam logic [7:0] BYTE_UPPER_R  = 8'h52;
  localparam logic [7:0] BYTE_UPPER_S  = 8'h53;
  localparam logic [7:0] BYTE_UPPER_Z  = 8'h5A;
  localparam logic [7:0] BYTE_LBRACKET = 8'h5B;
  localparam logic [7:0] BYTE_LOWER_A  = 8'h61;
  localparam logic [7:0] BYTE_LOWER_Z  = 8'h7A;
  localparam logic [7:0] BYTE_TILDE    = 8'h7E;
  localparam logic [7:0] BYTE_DEL      = 8'h7F;

  // Offsets: control bytes are shown as letters, lower case folds to upper.
  localparam logic [7:0] CTRL_OFFSET  = 8'd64;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;
  localparam logic [7:0] CTRL_LIMIT   = 8'd27;
  localparam logic [7:0] CODE_SAT     = 8'd255;
  localparam logic [7:0] TILDE_LIMIT  = 8'd25;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_ESC     = 5'b00010,
    PH_CSI     = 5'b00100,
    PH_CSI_MOD = 5'b01000,
    PH_SS3     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [4:0] key_kind;
    logic [7:0] char_value;
    logic [2:0] mods;
    logic [7:0] dispatch_byte;
  } result_t;

  // Key named by a CSI sequence ended with a tilde; code is 1 to 24.
  function automatic logic [4:0] tilde_kind(input logic [4:0] code);
    logic [4:0] kind;
    case (code)
      5'd1:    kind = KIND_HOME;
      5'd2:    kind = KIND_INS;
      5'd3:    kind = KIND_DEL;
      5'd4:    kind = KIND_END;
      5'd5:    kind = KIND_PGUP;
      5'd6:    kind = KIND_PGDN;
      5'd7:    kind = KIND_HOME;
      5'd8:    kind = KIND_END;
      5'd10:   kind = KIND_F0;
      5'd11:   kind = KIND_F1;
      5'd12:   kind = KIND_F2;
      5'd13:   kind = KIND_F3;
      5'd14:   kind = KIND_F4;
      5'd15:   kind = KIND_F5;
      5'd17:   kind = KIND_F6;
      5'd18:   kind = KIND_F7;
      5'd19:   kind = KIND_F8;
      5'd20:   kind = KIND_F9;
      5'd21:   kind = KIND_F10;
      5'd23:   kind = KIND_F11;
      5'd24:   kind = KIND_F12;
      default: kind = KIND_NONE;
    endcase
    return kind;
  endfunction

endpackage

@@ rtl/terminal_key_sequence_decoder.sv @@
// Top level of the terminal key sequence decoder: parser state, one-pass
// decode logic and the output register. Depends on tksd_pkg.
`timescale 1ns / 1ps

// Takes one terminal byte per item and returns at most one decoded key per
// byte: plain characters, ESC-prefixed alt keys, CSI letter and tilde forms
// with ';' modifier bytes, and SS3 F1 to F4. Each byte is decoded combinationally
// between the parser state and a one-deep output register, so a byte is
// accepted in every cycle as long as the output register is empty or being
// taken in that cycle. A result appears on the output in the cycle after the
// byte that completes it. Bytes that only advance a sequence produce no item.
module terminal_key_sequence_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] char_value, [8] shift_flag, [9] ctrl_flag, [10] alt_flag,
  // [18:11] dispatch_byte, [23:19] zero
  output logic [23:0] m_axis_tdata,
  output logic [4:0]  m_axis_tuser    // [4:0] key_kind
);

  tksd_pkg::phase_t  phase, phase_next;
  logic [7:0]        acc, acc_next;
  logic [2:0]        mods, mods_next;
  logic              out_valid;
  tksd_pkg::result_t out_res;

  logic              in_acc;
  logic              emit;
  tksd_pkg::result_t res;
  logic [7:0]        b;
  logic [11:0]       acc_sum;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  function automatic tksd_pkg::result_t plain_key(input logic [7:0] byt,
                                                  input logic [2:0] pre);
    tksd_pkg::result_t r;
    r.key_kind      = tksd_pkg::KIND_CHAR;
    r.char_value    = 8'd0;
    r.mods          = pre;
    r.dispatch_byte = byt;
    if (byt == tksd_pkg::BYTE_TAB) begin
      r.key_kind = tksd_pkg::KIND_TAB;
    end else if (byt == tksd_pkg::BYTE_CR) begin
      r.key_kind = tksd_pkg::KIND_ENTER;
    end else if (byt == tksd_pkg::BYTE_SPACE) begin
      r.key_kind = tksd_pkg::KIND_SPACE;
    end else if (byt == tksd_pkg::BYTE_DEL) begin
      r.key_kind = tksd_pkg::KIND_BKSP;
    end else if (byt < tksd_pkg::CTRL_LIMIT) begin
      r.mods[tksd_pkg::MOD_CTRL_BIT] = 1'b1;
      r.char_value = byt + tksd_pkg::CTRL_OFFSET;
    end else if (byt inside {[tksd_pkg::BYTE_UPPER_A:tksd_pkg::BYTE_UPPER_Z]}) begin
      r.mods[tksd_pkg::MOD_SHIFT_BIT] = 1'b1;
      r.char_value = byt;
    end else if (byt inside {[tksd_pkg::BYTE_LOWER_A:tksd_pkg::BYTE_LOWER_Z]}) begin
      r.char_value = byt - tksd_pkg::CASE_OFFSET;
    end else begin
      r.char_value = byt;
    end
    return r;
  endfunction

  // Decimal code times ten plus the new digit, in a width that cannot overflow.
  assign acc_sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'h00, b[3:0]};

  always_comb begin
    phase_next = phase;
    acc_next   = acc;
    mods_next  = mods;
    emit       = 1'b0;
    res        = '0;
    case (phase)
      tksd_pkg::PH_IDLE: begin
        if (b == tksd_pkg::BYTE_ESC) begin
          phase_next = tksd_pkg::PH_ESC;
        end else if (b != tksd_pkg::BYTE_NUL) begin
          emit = 1'b1;
          res  = plain_key(b, 3'b000);
        end
      end
      tksd_pkg::PH_ESC: begin
        acc_next  = 8'd0;
        mods_next = 3'b000;
        if (b == tksd_pkg::BYTE_NUL) begin
          phase_next = tksd_pkg::PH_IDLE;
        end else if (b == tksd_pkg::BYTE_LBRACKET) begin
          phase_next = tksd_pkg::PH_CSI;
        end else if (b == tksd_pkg::BYTE_UPPER_O) begin
          phase_next = tksd_pkg::PH_SS3;
        end else begin
          phase_next = tksd_pkg::PH_IDLE;
          emit       = 1'b1;
          res        = plain_key(b, 3'b010);
        end
      end
      tksd_pkg::PH_CSI: begin
        res.dispatch_byte = tksd_pkg::BYTE_LBRACKET;
        res.mods          = mods;
        res.key_kind      = tksd_pkg::KIND_NONE;
        if (b == tksd_pkg::BYTE_NUL) begin
          emit = 1'b1;
        end else if (b inside {[tksd_pkg::BYTE_UPPER_A:tksd_pkg::BYTE_UPPER_Z]}) begin
          emit = 1'b1;
          case (b)
            tksd_pkg::BYTE_UPPER_A: res.key_kind = tksd_pkg::KIND_UP;
            tksd_pkg::BYTE_UPPER_B: res.key_kind = tksd_pkg::KIND_DOWN;
            tksd_pkg::BYTE_UPPER_C: res.key_kind = tksd_pkg::KIND_RIGHT;
            tksd_pkg::BYTE_UPPER_D: res.key_kind = tksd_pkg::KIND_LEFT;
            tksd_pkg::BYTE_UPPER_F: res.key_kind = tksd_pkg::KIND_END;
            tksd_pkg::BYTE_UPPER_H: res.key_kind = tksd_pkg::KIND_HOME;
            tksd_pkg::BYTE_UPPER_Z: begin
              res.key_kind = tksd_pkg::KIND_TAB;
              res.mods[tksd_pkg::MOD_SHIFT_BIT] = 1'b1;
            end
            default: res.key_kind = tksd_pkg::KIND_NONE;
          endcase
        end else if (b inside {[tksd_pkg::BYTE_DIGIT_0:tksd_pkg::BYTE_DIGIT_9]}) begin
          acc_next = (acc_sum > {4'h0, tksd_pkg::CODE_SAT}) ? tksd_pkg::CODE_SAT
                                                             : acc_sum[7:0];
        end else if (b == tksd_pkg::BYTE_SEMI) begin
          phase_next = tksd_pkg::PH_CSI_MOD;
        end else if (b == tksd_pkg::BYTE_TILDE && acc != 8'd0
                     && acc < tksd_pkg::TILDE_LIMIT) begin
          emit         = 1'b1;
          res.key_kind = tksd_pkg::tilde_kind(acc[4:0]);
        end
        if (emit) begin
          phase_next = tksd_pkg::PH_IDLE;
          acc_next   = 8'd0;
          mods_next  = 3'b000;
        end
      end
      tksd_pkg::PH_CSI_MOD: begin
        // A modifier byte carries its value plus one; a zero byte adds nothing.
        if (b != tksd_pkg::BYTE_NUL) begin
          mods_next = mods | (b[2:0] - 3'd1);
        end
        phase_next = tksd_pkg::PH_CSI;
      end
      tksd_pkg::PH_SS3: begin
        if (b inside {[tksd_pkg::BYTE_DIGIT_0:tksd_pkg::BYTE_DIGIT_9]}) begin
          mods_next = mods | (b[2:0] - 3'd1);
        end else begin
          emit              = 1'b1;
          res.dispatch_byte = tksd_pkg::BYTE_UPPER_O;
          res.mods          = mods;
          case (b)
            tksd_pkg::BYTE_UPPER_P: res.key_kind = tksd_pkg::KIND_F1;
            tksd_pkg::BYTE_UPPER_Q: res.key_kind = tksd_pkg::KIND_F2;
            tksd_pkg::BYTE_UPPER_R: res.key_kind = tksd_pkg::KIND_F3;
            tksd_pkg::BYTE_UPPER_S: res.key_kind = tksd_pkg::KIND_F4;
            default:                res.key_kind = tksd_pkg::KIND_NONE;
          endcase
          phase_next = tksd_pkg::PH_IDLE;
          acc_next   = 8'd0;
          mods_next  = 3'b000;
        end
      end
      default: begin
        phase_next = tksd_pkg::PH_IDLE;
        acc_next   = 8'd0;
        mods_next  = 3'b000;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= tksd_pkg::PH_IDLE;
      acc       <= 8'd0;
      mods      <= 3'b000;
      out_valid <= 1'b0;
    end else begin
      if (in_acc) begin
        phase     <= phase_next;
        acc       <= acc_next;
        mods      <= mods_next;
        out_valid <= emit;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.key_kind;
  assign m_axis_tdata  = {5'b00000, out_res.dispatch_byte,
                          out_res.mods[tksd_pkg::MOD_ALT_BIT],
                          out_res.mods[tksd_pkg::MOD_CTRL_BIT],
                          out_res.mods[tksd_pkg::MOD_SHIFT_BIT],
                          out_res.char_value};

  // A zero byte while idle must leave the output empty.
  assert property (@(posedge clk) disable iff (rst)
    in_acc && phase == tksd_pkg::PH_IDLE && s_axis_tdata == tksd_pkg::BYTE_NUL
    |=> !m_axis_tvalid)
    else $error("result produced for a zero byte while idle");

  // The modifier byte phase is only ever entered from the CSI phase, and it
  // holds while no byte arrives.
  assert property (@(posedge clk) disable iff (rst)
    phase == tksd_pkg::PH_CSI_MOD
    |-> $past(phase) == tksd_pkg::PH_CSI || $past(phase) == tksd_pkg::PH_CSI_MOD)
    else $error("modifier phase entered from outside CSI");

  // No code or modifier is left over once a sequence has closed.
  assert property (@(posedge clk) disable iff (rst)
    phase == tksd_pkg::PH_IDLE |-> acc == 8'd0 && mods == 3'b000)
    else $error("stale sequence state while idle");

  // A control character is always shown as an upper-case letter.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == tksd_pkg::KIND_CHAR && m_axis_tdata[9]
    |-> m_axis_tdata[7:0] >= tksd_pkg::BYTE_UPPER_A
        && m_axis_tdata[7:0] <= tksd_pkg::BYTE_UPPER_Z)
    else $error("control character outside the letter range");

endmodule
